// ===== hdl/hbbtt_pkg.sv =====
`default_nettype none

package hbbtt_pkg;

	localparam int unsigned DEVICE_W = 8;
	localparam int unsigned BLOCK_W = 32;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned SLOT_FIELD_W = 5;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

	typedef enum logic [1:0] {
		CMD_ACQUIRE = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_PIN     = 2'd2,
		CMD_UNPIN   = 2'd3
	} command_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_FREE   = 2'd1,
		ST_COUNT_ERR = 2'd2
	} status_t;

endpackage

`default_nettype wire

// ===== hdl/hashed_block_buffer_tag_table.sv =====
`default_nettype none

// Tag table of SLOT_COUNT buffer slots grouped into BUCKET_COUNT hash buckets. A transaction
// is taken when start is high and busy is low; busy then stays high until the result has
// been produced. The result appears for exactly one cycle with done high and must be taken
// in that cycle, since nothing but done marks the result as new. An acquire first reduces
// the block number to its bucket by a reciprocal multiplication, then scans the slot table
// through its single read port one slot per cycle from the highest index down, stopping
// early on a hit. Release, pin and unpin read and update one slot; an out-of-range slot
// index finishes in the read state with no update.
module hashed_block_buffer_tag_table #(
	parameter int unsigned SLOT_COUNT = 32,
	parameter int unsigned BUCKET_COUNT = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  command,
	input  wire logic [7:0]  device,
	input  wire logic [31:0] block_number,
	input  wire logic [4:0]  slot_index,
	output logic             done,
	output logic [4:0]       granted_slot,
	output logic             was_hit,
	output logic             needs_fill,
	output logic [1:0]       status
);

	localparam int unsigned SW = $clog2(SLOT_COUNT);
	localparam int unsigned BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
	localparam int unsigned BL = $clog2(BUCKET_COUNT);
	localparam int unsigned XW = (SW > hbbtt_pkg::SLOT_FIELD_W) ? SW : hbbtt_pkg::SLOT_FIELD_W;
	localparam int unsigned PW = 2 * hbbtt_pkg::BLOCK_W + 1;
	localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);
	localparam logic [31:0] SLOT_LIMIT = 32'(SLOT_COUNT);
	localparam logic [hbbtt_pkg::BLOCK_W:0] RECIP = (hbbtt_pkg::BLOCK_W + 1)'(
		((65'd1 << (hbbtt_pkg::BLOCK_W + BL)) / 65'(BUCKET_COUNT)) + 65'd1);

	typedef struct packed {
		logic [hbbtt_pkg::DEVICE_W-1:0] device;
		logic [hbbtt_pkg::BLOCK_W-1:0]  block;
		logic [hbbtt_pkg::COUNT_W-1:0]  count;
		logic                           valid;
		logic [BW-1:0]                  bucket;
	} entry_t;

	typedef enum logic [2:0] {
		IDLE,
		HASH,
		SCAN,
		DRAIN,
		OP_READ,
		OP_EVAL
	} state_t;

	state_t state_q;

	entry_t mem_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] written_q;
	logic [BW-1:0] reset_bucket [SLOT_COUNT];

	hbbtt_pkg::command_t command_q;
	logic [hbbtt_pkg::DEVICE_W-1:0] device_q;
	logic [hbbtt_pkg::BLOCK_W-1:0] block_q;
	logic [hbbtt_pkg::SLOT_FIELD_W-1:0] index_q;

	logic [PW-1:0] hash_prod;
	logic [BW-1:0] hash_quot;
	logic [BW-1:0] hash_q;
	logic [BW-1:0] hash_n;

	logic [SW-1:0] scan_q;
	logic [SW-1:0] rd_addr;
	entry_t rd_rec_s1;
	logic rd_wr_s1;
	logic [SW-1:0] rd_slot_s1;
	logic eval_s1;
	entry_t eff;

	logic own_found_q, own_found_n;
	logic [SW-1:0] own_slot_q, own_slot_n;
	logic any_found_q, any_found_n;
	logic [SW-1:0] any_slot_q, any_slot_n;
	logic [BW-1:0] any_bkt_q, any_bkt_n;
	logic hit_now, free_now;

	logic [XW-1:0] index_ext;
	logic [SW-1:0] index_addr;
	logic index_bad;

	logic wr_en;
	logic [SW-1:0] wr_addr;
	entry_t wr_data;
	logic fin;
	logic [SW-1:0] res_slot;
	logic res_use_index;
	logic [XW-1:0] res_slot_ext;
	logic [hbbtt_pkg::SLOT_FIELD_W-1:0] res_gslot;
	logic res_hit;
	logic res_fill;
	hbbtt_pkg::status_t res_status;

	logic done_q;
	logic [hbbtt_pkg::SLOT_FIELD_W-1:0] granted_q;
	logic was_hit_q;
	logic needs_fill_q;
	hbbtt_pkg::status_t status_q;

	genvar gi;
	generate
		for (gi = 0; gi < SLOT_COUNT; gi++) begin : g_rbkt
			assign reset_bucket[gi] = BW'(gi % BUCKET_COUNT);
		end
	endgenerate

	assign busy = (state_q != IDLE);
	assign done = done_q;
	assign granted_slot = granted_q;
	assign was_hit = was_hit_q;
	assign needs_fill = needs_fill_q;
	assign status = status_q;

	assign index_ext = XW'(index_q);
	assign index_addr = index_ext[SW-1:0];
	assign index_bad = (32'(index_q) >= SLOT_LIMIT);

	// Remainder of the block number by the bucket count through a reciprocal multiplication.
	// Only the low bits of the quotient matter, since the remainder fits in the bucket width.
	assign hash_prod = PW'(block_q) * PW'(RECIP);
	assign hash_quot = hash_prod[hbbtt_pkg::BLOCK_W + BL +: BW];
	assign hash_n = block_q[BW-1:0] - hash_quot * BW'(BUCKET_COUNT);

	assign rd_addr = (state_q == OP_READ) ? index_addr : scan_q;

	always_ff @(posedge clk) begin
		rd_rec_s1 <= mem_q[rd_addr];
		rd_wr_s1 <= written_q[rd_addr];
		rd_slot_s1 <= rd_addr;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// A slot that was never written reads as its reset contents.
	always_comb begin
		eff = rd_rec_s1;
		if (!rd_wr_s1) begin
			eff.device = '0;
			eff.block = '0;
			eff.count = '0;
			eff.valid = 1'b0;
			eff.bucket = reset_bucket[rd_slot_s1];
		end
	end

	always_comb begin
		hit_now = eval_s1 && (eff.bucket == hash_q) && (eff.device == device_q) &&
			(eff.block == block_q);
		free_now = eval_s1 && (eff.count == '0);
		own_found_n = own_found_q;
		own_slot_n = own_slot_q;
		any_found_n = any_found_q;
		any_slot_n = any_slot_q;
		any_bkt_n = any_bkt_q;
		if (free_now && (eff.bucket == hash_q) && !own_found_q) begin
			own_found_n = 1'b1;
			own_slot_n = rd_slot_s1;
		end
		if (free_now && (!any_found_q || (eff.bucket < any_bkt_q))) begin
			any_found_n = 1'b1;
			any_slot_n = rd_slot_s1;
			any_bkt_n = eff.bucket;
		end
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = rd_slot_s1;
		wr_data = eff;
		fin = 1'b0;
		res_slot = rd_slot_s1;
		res_use_index = 1'b0;
		res_hit = 1'b0;
		res_fill = 1'b0;
		res_status = hbbtt_pkg::ST_OK;
		unique case (state_q)
			SCAN, DRAIN: begin
				if (hit_now) begin
					fin = 1'b1;
					res_hit = 1'b1;
					if (eff.count >= hbbtt_pkg::COUNT_MAX) begin
						res_status = hbbtt_pkg::ST_COUNT_ERR;
					end else begin
						wr_en = 1'b1;
						wr_data.count = eff.count + 8'd1;
						wr_data.valid = 1'b1;
						res_fill = !eff.valid;
					end
				end else if (state_q == DRAIN) begin
					fin = 1'b1;
					wr_data.device = device_q;
					wr_data.block = block_q;
					wr_data.count = 8'd1;
					wr_data.valid = 1'b1;
					wr_data.bucket = hash_q;
					if (own_found_n) begin
						wr_en = 1'b1;
						wr_addr = own_slot_n;
						res_slot = own_slot_n;
						res_fill = 1'b1;
					end else if (any_found_n) begin
						wr_en = 1'b1;
						wr_addr = any_slot_n;
						res_slot = any_slot_n;
						res_fill = 1'b1;
					end else begin
						res_slot = '0;
						res_status = hbbtt_pkg::ST_NO_FREE;
					end
				end
			end
			OP_READ: begin
				if (index_bad) begin
					fin = 1'b1;
					res_use_index = 1'b1;
					res_status = hbbtt_pkg::ST_COUNT_ERR;
				end
			end
			OP_EVAL: begin
				fin = 1'b1;
				res_use_index = 1'b1;
				case (command_q)
					hbbtt_pkg::CMD_PIN: begin
						if (eff.count >= hbbtt_pkg::COUNT_MAX) begin
							res_status = hbbtt_pkg::ST_COUNT_ERR;
						end else begin
							wr_en = 1'b1;
							wr_data.count = eff.count + 8'd1;
						end
					end
					default: begin
						if (eff.count == '0) begin
							res_status = hbbtt_pkg::ST_COUNT_ERR;
						end else begin
							wr_en = 1'b1;
							wr_data.count = eff.count - 8'd1;
						end
					end
				endcase
			end
			default: begin
			end
		endcase
		res_slot_ext = XW'(res_slot);
		res_gslot = res_use_index ? index_q : res_slot_ext[hbbtt_pkg::SLOT_FIELD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			done_q <= 1'b0;
			written_q <= '0;
			eval_s1 <= 1'b0;
			own_found_q <= 1'b0;
			any_found_q <= 1'b0;
			scan_q <= '0;
		end else begin
			done_q <= fin;
			eval_s1 <= (state_q == SCAN);
			if (fin) begin
				granted_q <= res_gslot;
				was_hit_q <= res_hit;
				needs_fill_q <= res_fill;
				status_q <= res_status;
			end
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			unique case (state_q)
				IDLE: begin
					if (start) begin
						command_q <= hbbtt_pkg::command_t'(command);
						device_q <= device;
						block_q <= block_number;
						index_q <= slot_index;
						hash_q <= '0;
						own_found_q <= 1'b0;
						any_found_q <= 1'b0;
						if (hbbtt_pkg::command_t'(command) == hbbtt_pkg::CMD_ACQUIRE) begin
							state_q <= HASH;
						end else begin
							state_q <= OP_READ;
						end
					end
				end
				HASH: begin
					hash_q <= hash_n;
					scan_q <= LAST_SLOT;
					state_q <= SCAN;
				end
				SCAN: begin
					own_found_q <= own_found_n;
					own_slot_q <= own_slot_n;
					any_found_q <= any_found_n;
					any_slot_q <= any_slot_n;
					any_bkt_q <= any_bkt_n;
					if (fin) begin
						state_q <= IDLE;
					end else if (scan_q == '0) begin
						state_q <= DRAIN;
					end else begin
						scan_q <= scan_q - 1'b1;
					end
				end
				DRAIN: begin
					state_q <= IDLE;
				end
				OP_READ: begin
					state_q <= fin ? IDLE : OP_EVAL;
				end
				OP_EVAL: begin
					state_q <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	a_start_takes: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_busy_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result");

	a_written_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		($past(written_q) & ~written_q) == '0)
		else $error("slot written mark was lost");

	a_no_free_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status_q == hbbtt_pkg::ST_NO_FREE)) |->
		((granted_slot == '0) && !was_hit && !needs_fill))
		else $error("no-free result carries slot data");

endmodule

`default_nettype wire
